@@ sv/point_rectangle_distance_macros.svh @@
// Assertion helpers for the point_rectangle_distance design.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef POINT_RECTANGLE_DISTANCE_MACROS_SVH
`define POINT_RECTANGLE_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
`define PRD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("prd assertion failed");
`define PRD_ASSERT_DLY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("prd delayed assertion failed");
`else
`define PRD_ASSERT(label, prop)
`define PRD_ASSERT_DLY(label, ante, dly, cons)
`endif
`endif

@@ sv/prd_pkg.sv @@
`default_nettype none
package prd_pkg;

    localparam int AXIS_FRAC_BITS = 18;
    localparam int AXIS_W         = 20;
    localparam int AXIS_VEC_W     = 3 * AXIS_W;
    localparam int COORD_W        = 32;
    localparam int SIZE_W         = 31;
    localparam int CFG_IDX_W      = 4;

    // projection widths
    localparam int D_W     = COORD_W + 1;
    localparam int PROD_W  = D_W + AXIS_W;
    localparam int RAW_W   = PROD_W + 2;
    localparam int LOC_W   = RAW_W + 1 - AXIS_FRAC_BITS;
    localparam int T_W     = LOC_W + 1;
    localparam int DSQ_W   = 2 * D_W;
    localparam int DSUM_W  = DSQ_W + 2;
    localparam int REACH_W = COORD_W + 1;
    localparam int RSQ_W   = 2 * REACH_W;

    // distance and nearest point widths
    localparam int MAG_W  = 32;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CP_W   = COORD_W + AXIS_W;
    localparam int CS_W   = CP_W + 1;
    localparam int RND_W  = CS_W + 2 - AXIS_FRAC_BITS;
    localparam int CL_W   = RND_W + 1;
    localparam int SQRT_W = 64;
    localparam int RT_W   = 33;

    localparam int SQRT_STEPS  = 32;
    localparam int PROJ_STAGES = 3;
    localparam int RES_STAGES  = 4;
    localparam int LATENCY     = PROJ_STAGES + RES_STAGES + SQRT_STEPS + 1;

    typedef enum logic [1:0] {
        CMD_DIST    = 2'd0,
        CMD_CLOSEST = 2'd1,
        CMD_ABOVE   = 2'd2,
        CMD_NEAR    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 4'd0,
        REG_ORIGIN_Y    = 4'd1,
        REG_ORIGIN_Z    = 4'd2,
        REG_LENGTH_AXIS = 4'd3,
        REG_WIDTH_AXIS  = 4'd4,
        REG_NORMAL_AXIS = 4'd5,
        REG_HALF_LENGTH = 4'd6,
        REG_HALF_WIDTH  = 4'd7
    } t_reg_idx;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
        logic [SIZE_W-1:0]          sphere_radius;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0]         distance;
        logic signed [COORD_W-1:0]  closest_x;
        logic signed [COORD_W-1:0]  closest_y;
        logic signed [COORD_W-1:0]  closest_z;
        logic                       flag;
    } t_rsp;

    typedef struct packed {
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic signed [COORD_W-1:0]  origin_z;
        logic [AXIS_VEC_W-1:0]      length_axis;
        logic [AXIS_VEC_W-1:0]      width_axis;
        logic [AXIS_VEC_W-1:0]      normal_axis;
        logic [SIZE_W-1:0]          half_length;
        logic [SIZE_W-1:0]          half_width;
        logic [COORD_W-1:0]         half_diag;
    } t_geom;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [LOC_W-1:0]    loc_l;
        logic signed [LOC_W-1:0]    loc_w;
        logic signed [LOC_W-1:0]    loc_n;
        logic                       above;
        logic [DSUM_W-1:0]          dsum;
        logic [RSQ_W-1:0]           reach_sq;
    } t_proj;

    typedef struct packed {
        logic                       dist_en;
        logic                       sat;
        logic signed [COORD_W-1:0]  closest_x;
        logic signed [COORD_W-1:0]  closest_y;
        logic signed [COORD_W-1:0]  closest_z;
        logic                       flag;
    } t_side;

    typedef struct packed {
        t_side                      side;
        logic [SQRT_W-1:0]          n;
    } t_pre;

    typedef struct packed {
        logic [SQRT_W-1:0]          n;
        logic [SQRT_W-1:0]          r;
    } t_root;

    // component k of a packed axis vector: x in the low bits, z in the high bits
    function automatic logic signed [AXIS_W-1:0] axis_comp(
        input logic [AXIS_VEC_W-1:0] v,
        input int                    k
    );
        return v[k*AXIS_W +: AXIS_W];
    endfunction

    // one digit step of the restoring square root
    function automatic t_root sqrt_step(input t_root s, input logic [SQRT_W-1:0] step_bit);
        t_root             o;
        logic [SQRT_W-1:0] trial;
        trial = s.r + step_bit;
        if (s.n >= trial) begin
            o.n = s.n - trial;
            o.r = (s.r >> 1) + step_bit;
        end else begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

@@ sv/prd_project.sv @@
`default_nettype none
module prd_project (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  prd_pkg::t_req        i_req,
    input  prd_pkg::t_geom       i_geom,
    output logic                 o_vld,
    output prd_pkg::t_proj       o_proj
);

    localparam logic signed [prd_pkg::RAW_W:0] RND_HALF =
        (prd_pkg::RAW_W + 1)'(2 ** (prd_pkg::AXIS_FRAC_BITS - 1));

    logic r_vld1, r_vld2, r_vld3;

    // stage 1: offsets from the origin
    prd_pkg::t_cmd                     r_cmd1;
    logic signed [prd_pkg::D_W-1:0]    r_d [3];
    logic signed [prd_pkg::D_W-1:0]    n_d [3];
    logic [prd_pkg::SIZE_W-1:0]        r_rad1;

    // stage 2: products
    prd_pkg::t_cmd                     r_cmd2;
    logic signed [prd_pkg::PROD_W-1:0] r_prod [3][3];
    logic signed [prd_pkg::PROD_W-1:0] n_prod [3][3];
    logic [prd_pkg::DSQ_W-1:0]         r_dsq [3];
    logic [prd_pkg::DSQ_W-1:0]         n_dsq [3];
    logic [prd_pkg::REACH_W-1:0]       r_reach;

    // stage 3: local coordinates
    prd_pkg::t_proj                    r_proj;
    prd_pkg::t_proj                    n_proj;

    logic [prd_pkg::AXIS_VEC_W-1:0]    w_axis [3];

    assign w_axis[0] = i_geom.length_axis;
    assign w_axis[1] = i_geom.width_axis;
    assign w_axis[2] = i_geom.normal_axis;

    always_comb begin
        n_d[0] = prd_pkg::D_W'(i_req.point_x) - prd_pkg::D_W'(i_geom.origin_x);
        n_d[1] = prd_pkg::D_W'(i_req.point_y) - prd_pkg::D_W'(i_geom.origin_y);
        n_d[2] = prd_pkg::D_W'(i_req.point_z) - prd_pkg::D_W'(i_geom.origin_z);
    end

    always_comb begin
        logic signed [prd_pkg::AXIS_W-1:0] ax;
        logic [prd_pkg::D_W-1:0]           m;
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                ax = prd_pkg::axis_comp(w_axis[a], k);
                n_prod[a][k] = r_d[k] * ax;
            end
        end
        for (int k = 0; k < 3; k++) begin
            m = r_d[k][prd_pkg::D_W-1] ? prd_pkg::D_W'(-r_d[k]) : prd_pkg::D_W'(r_d[k]);
            n_dsq[k] = prd_pkg::DSQ_W'(m) * prd_pkg::DSQ_W'(m);
        end
    end

    always_comb begin
        logic signed [prd_pkg::RAW_W-1:0] raw [3];
        logic signed [prd_pkg::RAW_W:0]   rnd [3];
        for (int a = 0; a < 3; a++) begin
            raw[a] = prd_pkg::RAW_W'(r_prod[a][0]) + prd_pkg::RAW_W'(r_prod[a][1])
                   + prd_pkg::RAW_W'(r_prod[a][2]);
            rnd[a] = (prd_pkg::RAW_W + 1)'(raw[a]) + RND_HALF;
        end
        n_proj.cmd   = r_cmd2;
        n_proj.loc_l = prd_pkg::LOC_W'(rnd[0] >>> prd_pkg::AXIS_FRAC_BITS);
        n_proj.loc_w = prd_pkg::LOC_W'(rnd[1] >>> prd_pkg::AXIS_FRAC_BITS);
        n_proj.loc_n = prd_pkg::LOC_W'(rnd[2] >>> prd_pkg::AXIS_FRAC_BITS);
        // strictly above: exact projection positive
        n_proj.above = !raw[2][prd_pkg::RAW_W-1] && (raw[2] != '0);
        n_proj.dsum  = prd_pkg::DSUM_W'(r_dsq[0]) + prd_pkg::DSUM_W'(r_dsq[1])
                     + prd_pkg::DSUM_W'(r_dsq[2]);
        n_proj.reach_sq = prd_pkg::RSQ_W'(r_reach) * prd_pkg::RSQ_W'(r_reach);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd1  <= i_req.cmd;
        r_d     <= n_d;
        r_rad1  <= i_req.sphere_radius;
        r_cmd2  <= r_cmd1;
        r_prod  <= n_prod;
        r_dsq   <= n_dsq;
        r_reach <= prd_pkg::REACH_W'(r_rad1) + prd_pkg::REACH_W'(i_geom.half_diag);
        r_proj  <= n_proj;
    end

    assign o_vld  = r_vld3;
    assign o_proj = r_proj;

endmodule
`default_nettype wire

@@ sv/prd_resolve.sv @@
`default_nettype none
module prd_resolve (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  prd_pkg::t_proj       i_proj,
    input  prd_pkg::t_geom       i_geom,
    output logic                 o_vld,
    output prd_pkg::t_pre        o_pre
);

    localparam int T_W  = prd_pkg::T_W;
    localparam int CL_W = prd_pkg::CL_W;
    localparam logic signed [prd_pkg::CS_W:0] RND_HALF =
        (prd_pkg::CS_W + 1)'(2 ** (prd_pkg::AXIS_FRAC_BITS - 1));
    localparam logic signed [CL_W-1:0] C_MAX =
        {{(CL_W - prd_pkg::COORD_W + 1){1'b0}}, {(prd_pkg::COORD_W - 1){1'b1}}};
    localparam logic signed [CL_W-1:0] C_MIN =
        {{(CL_W - prd_pkg::COORD_W + 1){1'b1}}, {(prd_pkg::COORD_W - 1){1'b0}}};

    function automatic logic signed [T_W-1:0] excess(
        input logic signed [T_W-1:0] v,
        input logic signed [T_W-1:0] h
    );
        if (v > h) return v - h;
        if (v < -h) return v + h;
        return '0;
    endfunction

    function automatic logic [T_W-1:0] abs_t(input logic signed [T_W-1:0] v);
        return v[T_W-1] ? T_W'(-v) : T_W'(v);
    endfunction

    function automatic logic signed [prd_pkg::COORD_W-1:0] clamp_t(
        input logic signed [T_W-1:0] v,
        input logic signed [T_W-1:0] h
    );
        if (v > h) return prd_pkg::COORD_W'(h);
        if (v < -h) return prd_pkg::COORD_W'(-h);
        return prd_pkg::COORD_W'(v);
    endfunction

    logic r_vld4, r_vld5, r_vld6, r_vld7;

    // stage 4: edge offsets, clamps, flags
    prd_pkg::t_cmd                       r_cmd4;
    logic [prd_pkg::MAG_W-1:0]           r_mag [3];
    logic [prd_pkg::MAG_W-1:0]           n_mag [3];
    logic                                r_sat4, n_sat4;
    logic signed [prd_pkg::COORD_W-1:0]  r_cx, r_cy, n_cx, n_cy;
    logic                                r_flag4, n_flag4;

    // stage 5: squares and products
    prd_pkg::t_cmd                       r_cmd5;
    logic [prd_pkg::SQ_W-1:0]            r_sq [3];
    logic [prd_pkg::SQ_W-1:0]            n_sq [3];
    logic signed [prd_pkg::CP_W-1:0]     r_cp [2][3];
    logic signed [prd_pkg::CP_W-1:0]     n_cp [2][3];
    logic                                r_sat5, r_flag5;

    // stage 6: sums and rounding
    prd_pkg::t_cmd                       r_cmd6;
    logic [prd_pkg::SQ_W-1:0]            r_sum, n_sum;
    logic                                r_sat6, n_sat6;
    logic signed [prd_pkg::RND_W-1:0]    r_rnd [3];
    logic signed [prd_pkg::RND_W-1:0]    n_rnd [3];
    logic                                r_flag6;

    // stage 7: world coordinates
    prd_pkg::t_pre                       r_pre, n_pre;

    logic [prd_pkg::AXIS_VEC_W-1:0]      w_axis [2];
    logic signed [prd_pkg::COORD_W-1:0]  w_org [3];

    assign w_axis[0] = i_geom.length_axis;
    assign w_axis[1] = i_geom.width_axis;
    assign w_org[0]  = i_geom.origin_x;
    assign w_org[1]  = i_geom.origin_y;
    assign w_org[2]  = i_geom.origin_z;

    always_comb begin
        logic signed [T_W-1:0] hl, hw, t [3];
        logic [T_W-1:0]        m;
        hl = signed'(T_W'(i_geom.half_length));
        hw = signed'(T_W'(i_geom.half_width));
        t[0] = excess(T_W'(i_proj.loc_l), hl);
        t[1] = excess(T_W'(i_proj.loc_w), hw);
        t[2] = T_W'(i_proj.loc_n);
        n_sat4 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            m = abs_t(t[k]);
            n_mag[k] = m[prd_pkg::MAG_W-1:0];
            if (|m[T_W-1:prd_pkg::MAG_W]) begin
                n_sat4 = 1'b1;
            end
        end
        n_cx = clamp_t(T_W'(i_proj.loc_l), hl);
        n_cy = clamp_t(T_W'(i_proj.loc_w), hw);
        unique case (i_proj.cmd)
            prd_pkg::CMD_ABOVE: n_flag4 = i_proj.above;
            prd_pkg::CMD_NEAR:  n_flag4 = i_proj.dsum < prd_pkg::DSUM_W'(i_proj.reach_sq);
            default:            n_flag4 = 1'b0;
        endcase
    end

    always_comb begin
        logic signed [prd_pkg::AXIS_W-1:0] ax;
        for (int k = 0; k < 3; k++) begin
            n_sq[k] = prd_pkg::SQ_W'(r_mag[k]) * prd_pkg::SQ_W'(r_mag[k]);
            ax = prd_pkg::axis_comp(w_axis[0], k);
            n_cp[0][k] = r_cx * ax;
            ax = prd_pkg::axis_comp(w_axis[1], k);
            n_cp[1][k] = r_cy * ax;
        end
    end

    always_comb begin
        logic [prd_pkg::SUM_W-1:0]       s;
        logic signed [prd_pkg::CS_W-1:0] cs;
        logic signed [prd_pkg::CS_W:0]   cr;
        s = prd_pkg::SUM_W'(r_sq[0]) + prd_pkg::SUM_W'(r_sq[1]) + prd_pkg::SUM_W'(r_sq[2]);
        n_sat6 = r_sat5 | (|s[prd_pkg::SUM_W-1:prd_pkg::SQ_W]);
        n_sum  = s[prd_pkg::SQ_W-1:0];
        for (int k = 0; k < 3; k++) begin
            cs = prd_pkg::CS_W'(r_cp[0][k]) + prd_pkg::CS_W'(r_cp[1][k]);
            cr = (prd_pkg::CS_W + 1)'(cs) + RND_HALF;
            n_rnd[k] = prd_pkg::RND_W'(cr >>> prd_pkg::AXIS_FRAC_BITS);
        end
    end

    always_comb begin
        logic signed [CL_W-1:0]             c;
        logic signed [prd_pkg::COORD_W-1:0] cl [3];
        for (int k = 0; k < 3; k++) begin
            c = CL_W'(r_rnd[k]) + CL_W'(w_org[k]);
            if (c > C_MAX) begin
                c = C_MAX;
            end else if (c < C_MIN) begin
                c = C_MIN;
            end
            cl[k] = (r_cmd6 == prd_pkg::CMD_CLOSEST) ? prd_pkg::COORD_W'(c) : '0;
        end
        n_pre.side.dist_en   = (r_cmd6 == prd_pkg::CMD_DIST);
        n_pre.side.sat       = r_sat6;
        n_pre.side.closest_x = cl[0];
        n_pre.side.closest_y = cl[1];
        n_pre.side.closest_z = cl[2];
        n_pre.side.flag      = r_flag6;
        n_pre.n              = r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else begin
            r_vld4 <= i_vld;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd4  <= i_proj.cmd;
        r_mag   <= n_mag;
        r_sat4  <= n_sat4;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_flag4 <= n_flag4;
        r_cmd5  <= r_cmd4;
        r_sq    <= n_sq;
        r_cp    <= n_cp;
        r_sat5  <= r_sat4;
        r_flag5 <= r_flag4;
        r_cmd6  <= r_cmd5;
        r_sum   <= n_sum;
        r_sat6  <= n_sat6;
        r_rnd   <= n_rnd;
        r_flag6 <= r_flag5;
        r_pre   <= n_pre;
    end

    assign o_vld = r_vld7;
    assign o_pre = r_pre;

endmodule
`default_nettype wire

@@ sv/prd_sqrt_pipe.sv @@
`default_nettype none
module prd_sqrt_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  prd_pkg::t_pre        i_pre,
    output logic                 o_done,
    output prd_pkg::t_rsp        o_rsp
);

    localparam int STEPS = prd_pkg::SQRT_STEPS;
    localparam int W     = prd_pkg::SQRT_W;

    logic            r_vld  [STEPS];
    prd_pkg::t_root  r_root [STEPS];
    prd_pkg::t_side  r_side [STEPS];
    prd_pkg::t_root  w_in   [STEPS];

    logic            r_done;
    prd_pkg::t_rsp   r_rsp, n_rsp;

    always_comb begin
        w_in[0].n = i_pre.n;
        w_in[0].r = '0;
        for (int i = 1; i < STEPS; i++) begin
            w_in[i] = r_root[i-1];
        end
    end

    // one root digit per stage, most significant first
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STEPS; i++) begin
            r_root[i] <= prd_pkg::sqrt_step(w_in[i], W'(1) << (W - 2 - 2 * i));
        end
        r_side[0] <= i_pre.side;
        for (int i = 1; i < STEPS; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STEPS; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < STEPS; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_done <= r_vld[STEPS-1];
        end
    end

    always_comb begin
        logic [prd_pkg::RT_W-1:0] rt;
        prd_pkg::t_root           last;
        prd_pkg::t_side           sd;
        last = r_root[STEPS-1];
        sd   = r_side[STEPS-1];
        // round to nearest: bump when remainder exceeds root
        rt = prd_pkg::RT_W'(last.r) + prd_pkg::RT_W'(last.n > last.r);
        if (!sd.dist_en) begin
            n_rsp.distance = '0;
        end else if (sd.sat || rt[prd_pkg::RT_W-1]) begin
            n_rsp.distance = '1;
        end else begin
            n_rsp.distance = rt[prd_pkg::COORD_W-1:0];
        end
        n_rsp.closest_x = sd.closest_x;
        n_rsp.closest_y = sd.closest_y;
        n_rsp.closest_z = sd.closest_z;
        n_rsp.flag      = sd.flag;
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

@@ sv/prd_diag.sv @@
`default_nettype none
module prd_diag (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [prd_pkg::SIZE_W-1:0]    i_half_length,
    input  logic [prd_pkg::SIZE_W-1:0]    i_half_width,
    output logic                          o_busy,
    output logic [prd_pkg::COORD_W-1:0]   o_half_diag
);

    localparam int W    = prd_pkg::SQRT_W;
    localparam int SQ_W = 2 * prd_pkg::SIZE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT,
        ST_ROUND
    } t_state;

    t_state                        r_state;
    logic [SQ_W-1:0]               r_lsq, r_wsq;
    prd_pkg::t_root                r_root;
    logic [W-1:0]                  r_bit;
    logic [prd_pkg::COORD_W-1:0]   r_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hd    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    r_lsq   <= SQ_W'(i_half_length) * SQ_W'(i_half_length);
                    r_wsq   <= SQ_W'(i_half_width) * SQ_W'(i_half_width);
                    r_state <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    r_root.n <= W'(r_lsq) + W'(r_wsq);
                    r_root.r <= '0;
                    r_bit    <= W'(1) << (W - 2);
                    r_state  <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_root <= prd_pkg::sqrt_step(r_root, r_bit);
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_hd    <= prd_pkg::COORD_W'(r_root.r + W'(r_root.n > r_root.r));
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_half_diag = r_hd;

endmodule
`default_nettype wire

@@ sv/point_rectangle_distance.sv @@
`default_nettype none
// Channel    Direction  Handshake                    Payload
// command    in         start / busy                 i_req  (prd_pkg::t_req)
// result     out        o_done strobe, one cycle     o_rsp  (prd_pkg::t_rsp)
// config     in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One command per clock while busy is low; the result passes through
// 3 projection stages, 4 resolve stages, 32 root-digit stages and an output register.
// A write to half_length or half_width runs the half-diagonal square root
// on its own shared unit; busy and !o_cfg_ready hold during that time.
// Reset is synchronous: valid bits, control state, configuration registers and the half diagonal clear.
// The result side cannot stall, so the pipeline never holds.
`include "point_rectangle_distance_macros.svh"
module point_rectangle_distance (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  prd_pkg::t_req                      i_req,
    output logic                               o_done,
    output prd_pkg::t_rsp                      o_rsp,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [prd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prd_pkg::AXIS_VEC_W-1:0]     i_cfg_data
);

    logic signed [prd_pkg::COORD_W-1:0]  r_origin_x, r_origin_y, r_origin_z;
    logic [prd_pkg::AXIS_VEC_W-1:0]      r_length_axis, r_width_axis, r_normal_axis;
    logic [prd_pkg::SIZE_W-1:0]          r_half_length, r_half_width;

    logic                                w_accept;
    logic                                w_cfg_acc;
    logic                                w_size_wr;
    logic                                w_diag_busy;
    logic [prd_pkg::COORD_W-1:0]         w_half_diag;
    prd_pkg::t_geom                      w_geom;
    logic                                w_proj_vld;
    prd_pkg::t_proj                      w_proj;
    logic                                w_pre_vld;
    prd_pkg::t_pre                       w_pre;

    assign busy        = w_diag_busy;
    assign o_cfg_ready = !w_diag_busy;
    assign w_accept    = start && !busy;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_size_wr   = w_cfg_acc && ((i_cfg_index == prd_pkg::REG_HALF_LENGTH) ||
                                       (i_cfg_index == prd_pkg::REG_HALF_WIDTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_origin_z    <= '0;
            r_length_axis <= '0;
            r_width_axis  <= '0;
            r_normal_axis <= '0;
            r_half_length <= '0;
            r_half_width  <= '0;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                prd_pkg::REG_ORIGIN_X:    r_origin_x    <= i_cfg_data[prd_pkg::COORD_W-1:0];
                prd_pkg::REG_ORIGIN_Y:    r_origin_y    <= i_cfg_data[prd_pkg::COORD_W-1:0];
                prd_pkg::REG_ORIGIN_Z:    r_origin_z    <= i_cfg_data[prd_pkg::COORD_W-1:0];
                prd_pkg::REG_LENGTH_AXIS: r_length_axis <= i_cfg_data;
                prd_pkg::REG_WIDTH_AXIS:  r_width_axis  <= i_cfg_data;
                prd_pkg::REG_NORMAL_AXIS: r_normal_axis <= i_cfg_data;
                prd_pkg::REG_HALF_LENGTH: r_half_length <= i_cfg_data[prd_pkg::SIZE_W-1:0];
                prd_pkg::REG_HALF_WIDTH:  r_half_width  <= i_cfg_data[prd_pkg::SIZE_W-1:0];
                default: begin
                    // drop writes outside the register map
                end
            endcase
        end
    end

    always_comb begin
        w_geom.origin_x    = r_origin_x;
        w_geom.origin_y    = r_origin_y;
        w_geom.origin_z    = r_origin_z;
        w_geom.length_axis = r_length_axis;
        w_geom.width_axis  = r_width_axis;
        w_geom.normal_axis = r_normal_axis;
        w_geom.half_length = r_half_length;
        w_geom.half_width  = r_half_width;
        w_geom.half_diag   = w_half_diag;
    end

    prd_diag u_diag (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_size_wr),
        .i_half_length (r_half_length),
        .i_half_width  (r_half_width),
        .o_busy        (w_diag_busy),
        .o_half_diag   (w_half_diag)
    );

    prd_project u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_req   (i_req),
        .i_geom  (w_geom),
        .o_vld   (w_proj_vld),
        .o_proj  (w_proj)
    );

    prd_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_proj_vld),
        .i_proj  (w_proj),
        .i_geom  (w_geom),
        .o_vld   (w_pre_vld),
        .o_pre   (w_pre)
    );

    prd_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_pre_vld),
        .i_pre   (w_pre),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    `PRD_ASSERT_DLY(a_latency, w_accept, prd_pkg::LATENCY, o_done)
    `PRD_ASSERT(a_size_busy, w_size_wr |=> busy)
    `PRD_ASSERT(a_dist_only, o_done && (o_rsp.distance != '0) |-> !o_rsp.flag && (o_rsp.closest_x == '0))

endmodule
`default_nettype wire

@@ verif/point_rectangle_distance_test.sv @@
`default_nettype none
module point_rectangle_distance_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam logic [prd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd9;
    localparam logic [prd_pkg::AXIS_W-1:0] AXIS_ONE  = 20'h40000;
    localparam logic [prd_pkg::AXIS_W-1:0] AXIS_DIAG = 20'h2D413;

    typedef struct {
        bit                                  is_cfg;
        logic [prd_pkg::CFG_IDX_W-1:0]       idx;
        logic [prd_pkg::AXIS_VEC_W-1:0]      data;
        prd_pkg::t_req                       req;
    } t_op;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    prd_pkg::t_req                       i_req;
    logic                                o_done;
    prd_pkg::t_rsp                       o_rsp;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [prd_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [prd_pkg::AXIS_VEC_W-1:0]      i_cfg_data;

    point_rectangle_distance u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_op            op_q[$];
    prd_pkg::t_rsp  expected_rsp_q[$];
    int             n_sent, n_recv;
    int             gap;
    bit             burst;
    int             mismatches;
    int             idle_cycles;

    // geometry as the block should hold it
    longint             geo_org[3];
    logic [59:0]        geo_axis[3];
    logic [63:0]        geo_hl, geo_hw;
    logic [31:0]        geo_hdiag;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sqrt_nearest(logic [63:0] n);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n > r) r = r + 1;
        return r;
    endfunction

    function automatic longint comp_of(int a, int k);
        logic signed [prd_pkg::AXIS_W-1:0] c;
        c = geo_axis[a][k*prd_pkg::AXIS_W +: prd_pkg::AXIS_W];
        return longint'(c);
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic prd_pkg::t_rsp predict_rsp(prd_pkg::t_req q);
        prd_pkg::t_rsp e;
        longint      dv[3], raw[3], loc[3], t[3];
        longint      hl, hw, cx, cy, s, v;
        logic [63:0] m;
        logic [65:0] sum;
        logic [69:0] acc, m70, reach;
        logic [63:0] r;
        bit          sat;
        e = '0;
        hl = longint'(geo_hl);
        hw = longint'(geo_hw);
        dv[0] = longint'(q.point_x) - geo_org[0];
        dv[1] = longint'(q.point_y) - geo_org[1];
        dv[2] = longint'(q.point_z) - geo_org[2];
        for (int a = 0; a < 3; a++) begin
            raw[a] = 0;
            for (int k = 0; k < 3; k++) raw[a] += dv[k] * comp_of(a, k);
            loc[a] = (raw[a] + (longint'(1) << (prd_pkg::AXIS_FRAC_BITS - 1)))
                     >>> prd_pkg::AXIS_FRAC_BITS;
        end
        case (q.cmd)
            prd_pkg::CMD_DIST: begin
                t[0] = (loc[0] > hl) ? loc[0] - hl : (loc[0] < -hl) ? loc[0] + hl : 0;
                t[1] = (loc[1] > hw) ? loc[1] - hw : (loc[1] < -hw) ? loc[1] + hw : 0;
                t[2] = loc[2];
                sat = 0;
                sum = '0;
                for (int k = 0; k < 3; k++) begin
                    m = magnitude(t[k]);
                    if (m >= 64'h1_0000_0000) sat = 1;
                    else sum = sum + {2'b00, m * m};
                end
                if (sum[65:64] != 0) sat = 1;
                if (sat) begin
                    e.distance = 32'hFFFF_FFFF;
                end else begin
                    r = sqrt_nearest(sum[63:0]);
                    e.distance = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
                end
            end
            prd_pkg::CMD_CLOSEST: begin
                cx = (loc[0] > hl) ? hl : (loc[0] < -hl) ? -hl : loc[0];
                cy = (loc[1] > hw) ? hw : (loc[1] < -hw) ? -hw : loc[1];
                for (int k = 0; k < 3; k++) begin
                    s = cx * comp_of(0, k) + cy * comp_of(1, k);
                    v = ((s + (longint'(1) << (prd_pkg::AXIS_FRAC_BITS - 1)))
                         >>> prd_pkg::AXIS_FRAC_BITS) + geo_org[k];
                    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
                    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
                    case (k)
                        0: e.closest_x = v[31:0];
                        1: e.closest_y = v[31:0];
                        default: e.closest_z = v[31:0];
                    endcase
                end
            end
            prd_pkg::CMD_ABOVE: e.flag = (raw[2] > 0);
            default: begin
                acc = '0;
                for (int k = 0; k < 3; k++) begin
                    m70 = {6'd0, magnitude(dv[k])};
                    acc = acc + m70 * m70;
                end
                reach = {39'd0, q.sphere_radius} + {38'd0, geo_hdiag};
                e.flag = (acc < reach * reach);
            end
        endcase
        return e;
    endfunction

    // driver: commands and register writes from the pending queue
    always @(posedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_req       <= '0;
            i_cfg_valid <= 1'b0;
            i_cfg_index <= '0;
            i_cfg_data  <= '0;
            n_sent      <= 0;
            gap         <= 0;
            burst       <= 1'b0;
        end else begin
            if (start && !busy) n_sent <= n_sent + 1;
            if ($urandom_range(0, 39) == 0) burst <= ~burst;
            if ((start && busy) || (i_cfg_valid && !o_cfg_ready)) begin
                // hold the current transaction
            end else if (gap != 0) begin
                gap         <= gap - 1;
                start       <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (op_q.size() == 0) begin
                start       <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (op_q[0].is_cfg) begin
                start <= 1'b0;
                // write only with the pipeline drained
                if (!start && n_sent == n_recv) begin
                    op = op_q.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= op.idx;
                    i_cfg_data  <= op.data;
                    gap         <= burst ? 0 : $urandom_range(0, 12);
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end else begin
                op = op_q.pop_front();
                i_cfg_valid <= 1'b0;
                start       <= 1'b1;
                i_req       <= op.req;
                gap         <= burst ? 0 : $urandom_range(0, 12);
            end
        end
    end

    // monitor: track register writes, predict on accept, check on done
    always @(posedge i_clk) begin
        prd_pkg::t_rsp e;
        bit            active;
        if (!i_rst_n) begin
            n_recv      <= 0;
            idle_cycles <= 0;
            mismatches  = 0;
            for (int k = 0; k < 3; k++) begin
                geo_org[k]  = 0;
                geo_axis[k] = '0;
            end
            geo_hl    = '0;
            geo_hw    = '0;
            geo_hdiag = '0;
        end else begin
            active = 0;
            if (i_cfg_valid && o_cfg_ready) begin
                active = 1;
                case (i_cfg_index)
                    prd_pkg::REG_ORIGIN_X: geo_org[0] = longint'($signed(i_cfg_data[31:0]));
                    prd_pkg::REG_ORIGIN_Y: geo_org[1] = longint'($signed(i_cfg_data[31:0]));
                    prd_pkg::REG_ORIGIN_Z: geo_org[2] = longint'($signed(i_cfg_data[31:0]));
                    prd_pkg::REG_LENGTH_AXIS: geo_axis[0] = i_cfg_data;
                    prd_pkg::REG_WIDTH_AXIS:  geo_axis[1] = i_cfg_data;
                    prd_pkg::REG_NORMAL_AXIS: geo_axis[2] = i_cfg_data;
                    prd_pkg::REG_HALF_LENGTH: geo_hl = {33'd0, i_cfg_data[30:0]};
                    prd_pkg::REG_HALF_WIDTH:  geo_hw = {33'd0, i_cfg_data[30:0]};
                    default: ;
                endcase
                if (i_cfg_index == prd_pkg::REG_HALF_LENGTH ||
                    i_cfg_index == prd_pkg::REG_HALF_WIDTH)
                    geo_hdiag = 32'(sqrt_nearest(geo_hl * geo_hl + geo_hw * geo_hw));
            end
            if (start && !busy) begin
                active = 1;
                expected_rsp_q.push_back(predict_rsp(i_req));
            end
            if (o_done) begin
                active = 1;
                n_recv <= n_recv + 1;
                if (expected_rsp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %h", o_rsp);
                end else begin
                    e = expected_rsp_q.pop_front();
                    if (o_rsp.distance !== e.distance || o_rsp.closest_x !== e.closest_x ||
                        o_rsp.closest_y !== e.closest_y ||
                        o_rsp.closest_z !== e.closest_z || o_rsp.flag !== e.flag) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp d=%h c=%h,%h,%h f=%b got d=%h c=%h,%h,%h f=%b",
                                     e.distance, e.closest_x, e.closest_y, e.closest_z,
                                     e.flag, o_rsp.distance, o_rsp.closest_x,
                                     o_rsp.closest_y, o_rsp.closest_z, o_rsp.flag);
                    end
                end
            end
            if (active) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    longint gen_org[3];

    task automatic push_cfg(logic [prd_pkg::CFG_IDX_W-1:0] idx,
                            logic [prd_pkg::AXIS_VEC_W-1:0] data);
        t_op op;
        op.is_cfg = 1;
        op.idx    = idx;
        op.data   = data;
        op.req    = '0;
        op_q.push_back(op);
        if (idx <= prd_pkg::REG_ORIGIN_Z) gen_org[idx] = longint'($signed(data[31:0]));
    endtask

    task automatic push_cmd(prd_pkg::t_cmd c, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic [30:0] rad);
        t_op op;
        op.is_cfg            = 0;
        op.idx               = '0;
        op.data              = '0;
        op.req.cmd           = c;
        op.req.point_x       = x;
        op.req.point_y       = y;
        op.req.point_z       = z;
        op.req.sphere_radius = rad;
        op_q.push_back(op);
    endtask

    function automatic logic [31:0] pick_coord(longint o);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h0;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: return o[31:0] + (int'($urandom) >>> $urandom_range(6, 26));
        endcase
    endfunction

    function automatic logic [30:0] pick_radius();
        case ($urandom_range(0, 4))
            0: return 31'h7FFF_FFFF;
            1: return 31'h0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            push_cmd(prd_pkg::t_cmd'($urandom_range(0, 3)), pick_coord(gen_org[0]),
                     pick_coord(gen_org[1]), pick_coord(gen_org[2]), pick_radius());
    endtask

    function automatic logic [59:0] unit_vec(int k, bit neg);
        logic [59:0] v;
        v = '0;
        v[k*prd_pkg::AXIS_W +: prd_pkg::AXIS_W] = neg ? -AXIS_ONE : AXIS_ONE;
        return v;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        for (int k = 0; k < 3; k++) gen_org[k] = 0;

        // reset geometry: everything collapses to the origin
        for (int c = 0; c < 4; c++)
            push_cmd(prd_pkg::t_cmd'(c), 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                     31'h7FFF_FFFF);

        // plain frame: axes along x, y, z
        push_cfg(prd_pkg::REG_ORIGIN_X, 60'h0_0001_0000);
        push_cfg(prd_pkg::REG_ORIGIN_Y, 60'hF_FFFE_0000);
        push_cfg(prd_pkg::REG_ORIGIN_Z, 60'h0_0003_0000);
        push_cfg(prd_pkg::REG_LENGTH_AXIS, unit_vec(0, 0));
        push_cfg(prd_pkg::REG_WIDTH_AXIS, unit_vec(1, 0));
        push_cfg(prd_pkg::REG_NORMAL_AXIS, unit_vec(2, 0));
        push_cfg(prd_pkg::REG_HALF_LENGTH, 60'h2_0000);
        push_cfg(prd_pkg::REG_HALF_WIDTH, 60'h1_0000);
        // centre, on plane, just above, just below, outside corner, then extreme points and near tests
        push_cmd(prd_pkg::CMD_DIST, 32'h1_0000, 32'hFFFE_0000, 32'h3_0000, 31'd0);
        push_cmd(prd_pkg::CMD_ABOVE, 32'h1_0000, 32'hFFFE_0000, 32'h3_0000, 31'd0);
        push_cmd(prd_pkg::CMD_ABOVE, 32'h1_0000, 32'hFFFE_0000, 32'h3_0001, 31'd0);
        push_cmd(prd_pkg::CMD_ABOVE, 32'h1_0000, 32'hFFFE_0000, 32'h2_FFFF, 31'd0);
        push_cmd(prd_pkg::CMD_DIST, 32'h9_0000, 32'h5_0000, 32'h7_0000, 31'd0);
        push_cmd(prd_pkg::CMD_CLOSEST, 32'h9_0000, 32'h5_0000, 32'h7_0000, 31'd0);
        push_cmd(prd_pkg::CMD_CLOSEST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        push_cmd(prd_pkg::CMD_DIST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        push_cmd(prd_pkg::CMD_NEAR, 32'h1_0000, 32'hFFFE_0000, 32'h3_0000, 31'd0);
        push_cmd(prd_pkg::CMD_NEAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 31'h7FFF_FFFF);
        push_cmd(prd_pkg::CMD_NEAR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
        push_cmd(prd_pkg::CMD_NEAR, 32'h3_3C6F, 32'hFFFE_0000, 32'h3_0000, 31'd0);
        push_random(100);

        // rotated frame, extreme origin, largest sizes
        push_cfg(prd_pkg::REG_ORIGIN_X, 60'h0_7FFF_FFFF);
        push_cfg(prd_pkg::REG_ORIGIN_Y, 60'hF_8000_0000);
        push_cfg(prd_pkg::REG_ORIGIN_Z, 60'h0);
        push_cfg(prd_pkg::REG_LENGTH_AXIS, unit_vec(2, 1));
        push_cfg(prd_pkg::REG_WIDTH_AXIS, unit_vec(0, 0));
        push_cfg(prd_pkg::REG_NORMAL_AXIS, unit_vec(1, 1));
        push_cfg(prd_pkg::REG_HALF_LENGTH, 60'h7FFF_FFFF);
        push_cfg(prd_pkg::REG_HALF_WIDTH, 60'h7FFF_FFFF);
        push_cmd(prd_pkg::CMD_DIST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        push_cmd(prd_pkg::CMD_CLOSEST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        push_random(110);

        // arbitrary axes and sizes, plus a write to an unused index
        push_cfg(prd_pkg::REG_ORIGIN_X, 60'({$urandom, $urandom}));
        push_cfg(prd_pkg::REG_ORIGIN_Y, 60'({$urandom, $urandom}));
        push_cfg(prd_pkg::REG_ORIGIN_Z, 60'({$urandom, $urandom}));
        push_cfg(prd_pkg::REG_LENGTH_AXIS, 60'({$urandom, $urandom}));
        push_cfg(prd_pkg::REG_WIDTH_AXIS, 60'({$urandom, $urandom}));
        push_cfg(prd_pkg::REG_NORMAL_AXIS, 60'({$urandom, $urandom}));
        push_cfg(prd_pkg::REG_HALF_LENGTH, 60'({$urandom, $urandom}));
        push_cfg(prd_pkg::REG_HALF_WIDTH, 60'({$urandom, $urandom}));
        push_cfg(CFG_IDX_UNUSED, 60'({$urandom, $urandom}));
        push_random(110);

        // diagonal frame, degenerate zero-size rectangle
        push_cfg(prd_pkg::REG_ORIGIN_X, 60'h0_0000_0000);
        push_cfg(prd_pkg::REG_ORIGIN_Y, 60'h0_0010_0000);
        push_cfg(prd_pkg::REG_ORIGIN_Z, 60'hF_FFF0_0000);
        push_cfg(prd_pkg::REG_LENGTH_AXIS, {20'h0, AXIS_DIAG, AXIS_DIAG});
        push_cfg(prd_pkg::REG_WIDTH_AXIS, {20'h0, AXIS_DIAG, -AXIS_DIAG});
        push_cfg(prd_pkg::REG_NORMAL_AXIS, {AXIS_ONE, 40'h0});
        push_cfg(prd_pkg::REG_HALF_LENGTH, 60'h0);
        push_cfg(prd_pkg::REG_HALF_WIDTH, 60'h0);
        push_random(110);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (!(op_q.size() == 0 && !start && !i_cfg_valid && n_sent == n_recv));
        repeat (prd_pkg::LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_rsp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+sv
sv/prd_pkg.sv
sv/prd_project.sv
sv/prd_resolve.sv
sv/prd_sqrt_pipe.sv
sv/prd_diag.sv
sv/point_rectangle_distance.sv
verif/point_rectangle_distance_test.sv
